### src/crc32_frame_header_checker_defines.svh
// Assertion helpers for the checker's frame engine.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CRC32_FRAME_HEADER_CHECKER_DEFINES_SVH
`define CRC32_FRAME_HEADER_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define CRCFHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define CRCFHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/crcfhc_pkg.sv
package crcfhc_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int POS_W        = $clog2(HEADER_BYTES + 1);

  localparam int CC_W   = 5;
  localparam int CAP_W  = 31;
  localparam int PROD_W = CAP_W + CC_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CC_W-1:0] MAX_CHANNELS = 5'd16;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [7:0]  MAGIC_A  = 8'hEB;
  localparam logic [7:0]  MAGIC_B  = 8'h71;
  localparam logic [7:0]  FRAME_VERSION = 8'h01;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 8'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CORRUPT   = 2'd1,
    ST_TOO_SMALL = 2'd2
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [CC_W-1:0]  channel_count;
    logic [CAP_W-1:0] output_capacity;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] sequence_number;
    logic [30:0] record_count;
  } result_t;

  // Reflected CRC-32 update for one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

endpackage

### src/crcfhc_in_stage.sv
module crcfhc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                consume,
  output crcfhc_pkg::in_beat_t beat
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  assign in_tready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;
  assign beat.last  = last_r;

endmodule

### src/crcfhc_frame_engine.sv
`include "crc32_frame_header_checker_defines.svh"

module crcfhc_frame_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crcfhc_pkg::in_beat_t beat,
  input  crcfhc_pkg::cfg_t     cfg,
  input  logic                 out_free,
  output logic                 consume,
  output crcfhc_pkg::result_t  res
);

  logic [crcfhc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        hdr_r, hdr_nxt;

  logic [31:0] crc_upd, exp_upd, seq_upd, cnt_upd;
  logic        hdr_upd;
  logic [31:0] byte_shifted;
  logic [crcfhc_pkg::PROD_W-1:0] product;
  crcfhc_pkg::status_t status;

  // A last beat waits until the output register can take its result.
  assign consume = beat.valid && (!beat.last || out_free);

  always_comb begin
    byte_shifted = {24'd0, beat.data} << {pos_r[1:0], 3'b000};

    hdr_upd = hdr_r;
    if (pos_r == 0 && beat.data != crcfhc_pkg::MAGIC_A)       hdr_upd = 1'b0;
    if (pos_r == 1 && beat.data != crcfhc_pkg::MAGIC_B)       hdr_upd = 1'b0;
    if (pos_r == 2 && beat.data != crcfhc_pkg::FRAME_VERSION) hdr_upd = 1'b0;
    if (pos_r == 3 && beat.data != 8'd0)                      hdr_upd = 1'b0;

    exp_upd = (pos_r >= 4 && pos_r < 8)   ? (exp_r | byte_shifted) : exp_r;
    seq_upd = (pos_r >= 8 && pos_r < 12)  ? (seq_r | byte_shifted) : seq_r;
    cnt_upd = (pos_r >= 12 && pos_r < 16) ? (cnt_r | byte_shifted) : cnt_r;
    crc_upd = (pos_r >= 8) ? crcfhc_pkg::crc_byte(crc_r, beat.data) : crc_r;

    product = crcfhc_pkg::PROD_W'(cnt_upd[30:0]) * crcfhc_pkg::PROD_W'(cfg.channel_count);

    priority if (cfg.channel_count == '0 || cfg.channel_count > crcfhc_pkg::MAX_CHANNELS) begin
      status = crcfhc_pkg::ST_CORRUPT;
    end else if (pos_r < crcfhc_pkg::POS_W'(crcfhc_pkg::HEADER_BYTES - 1)) begin
      status = crcfhc_pkg::ST_CORRUPT;
    end else if (!hdr_upd) begin
      status = crcfhc_pkg::ST_CORRUPT;
    end else if ((crc_upd ^ crcfhc_pkg::CRC_ONES) != exp_upd) begin
      status = crcfhc_pkg::ST_CORRUPT;
    end else if (cnt_upd[31]) begin
      status = crcfhc_pkg::ST_CORRUPT;
    end else if (product > crcfhc_pkg::PROD_W'(cfg.output_capacity)) begin
      status = crcfhc_pkg::ST_TOO_SMALL;
    end else begin
      status = crcfhc_pkg::ST_OK;
    end

    res.valid           = consume && beat.last;
    res.status          = status;
    res.sequence_number = (status == crcfhc_pkg::ST_OK) ? seq_upd : 32'd0;
    res.record_count    = (status == crcfhc_pkg::ST_OK) ? cnt_upd[30:0] : 31'd0;

    pos_nxt = pos_r;
    crc_nxt = crc_r;
    exp_nxt = exp_r;
    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    hdr_nxt = hdr_r;
    if (consume) begin
      if (beat.last) begin
        pos_nxt = '0;
        crc_nxt = crcfhc_pkg::CRC_ONES;
        exp_nxt = '0;
        seq_nxt = '0;
        cnt_nxt = '0;
        hdr_nxt = 1'b1;
      end else begin
        if (pos_r < crcfhc_pkg::POS_W'(crcfhc_pkg::HEADER_BYTES)) begin
          pos_nxt = pos_r + 1'b1;
        end
        crc_nxt = crc_upd;
        exp_nxt = exp_upd;
        seq_nxt = seq_upd;
        cnt_nxt = cnt_upd;
        hdr_nxt = hdr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= crcfhc_pkg::CRC_ONES;
      exp_r <= '0;
      seq_r <= '0;
      cnt_r <= '0;
      hdr_r <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      exp_r <= exp_nxt;
      seq_r <= seq_nxt;
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  `CRCFHC_ASSERT_NOW(a_err_zero, res.valid && res.status != crcfhc_pkg::ST_OK,
    res.sequence_number == 32'd0 && res.record_count == 31'd0,
    "error result carries nonzero sequence or count")
  `CRCFHC_ASSERT_NOW(a_pos_sat, 1'b1,
    pos_r <= crcfhc_pkg::POS_W'(crcfhc_pkg::HEADER_BYTES),
    "byte position ran past the header size")
  `CRCFHC_ASSERT_NEXT(a_frame_clear, consume && beat.last,
    pos_r == '0 && crc_r == crcfhc_pkg::CRC_ONES && hdr_r,
    "frame state not cleared after the last beat")
  `CRCFHC_ASSERT_NEXT(a_pos_step,
    consume && !beat.last && pos_r < crcfhc_pkg::POS_W'(crcfhc_pkg::HEADER_BYTES),
    pos_r == $past(pos_r) + 1'b1,
    "byte position did not advance on a header beat")

endmodule

### src/crc32_frame_header_checker.sv
// Channel | Dir | Handshake          | Payload
// in_     | in  | tvalid/tready      | tdata[7:0] frame_byte, tlast last_byte
// out_    | out | tvalid/tready      | tuser[1:0] status, tdata sequence/count
// cfg_    | in  | valid/ready        | index[7:0], data[31:0]
//
// One byte beat is accepted per cycle while no last beat is held back;
// out_tvalid follows its frame's last beat (input register, then output
// register). The CRC byte update and the record capacity check sit between
// those two. Reset is synchronous and active low; it restores all but the
// data registers. A stalled result holds only the last beat of the next
// frame; other beats keep flowing. Configuration writes are always taken.
module crc32_frame_header_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] frame_byte
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] sequence_number, [62:32] record_count, [63] zero
  output logic [63:0]                       out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcfhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crcfhc_pkg::CFG_DATA_W-1:0] cfg_data
);

  crcfhc_pkg::in_beat_t beat;
  crcfhc_pkg::cfg_t     cfg;
  crcfhc_pkg::result_t  res;
  logic                 consume;
  logic                 out_free;

  logic [crcfhc_pkg::CC_W-1:0]  cc_r;
  logic [crcfhc_pkg::CAP_W-1:0] cap_r;

  logic                out_valid_r, out_valid_nxt;
  crcfhc_pkg::status_t status_r;
  logic [31:0]         seq_r;
  logic [30:0]         cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= crcfhc_pkg::CC_W'(1);
      cap_r <= {crcfhc_pkg::CAP_W{1'b1}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crcfhc_pkg::REG_CHANNEL_COUNT:   cc_r  <= cfg_data[crcfhc_pkg::CC_W-1:0];
        crcfhc_pkg::REG_OUTPUT_CAPACITY: cap_r <= cfg_data[crcfhc_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.channel_count   = cc_r;
  assign cfg.output_capacity = cap_r;

  crcfhc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .consume   (consume),
    .beat      (beat)
  );

  crcfhc_frame_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .cfg      (cfg),
    .out_free (out_free),
    .consume  (consume),
    .res      (res)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= res.status;
      seq_r    <= res.sequence_number;
      cnt_r    <= res.record_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, cnt_r, seq_r};
  assign out_tuser  = status_r;

endmodule
